// File: rtl/liba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// liba_pkg
// Shared types and constants of the linked indexed block allocator.
// ----------------------------------------------------------------------------
package liba_pkg;

  localparam int NUM_BLOCKS = 256;
  localparam int NUM_FILES  = 256;
  localparam int BW         = $clog2(NUM_BLOCKS);
  localparam int CW         = $clog2(NUM_BLOCKS + 1);

  localparam logic [1:0] ACT_CREATE  = 2'd0;
  localparam logic [1:0] ACT_RESIZE  = 2'd1;
  localparam logic [1:0] ACT_DELETE  = 2'd2;
  localparam logic [1:0] ACT_INVALID = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOFILE  = 3'd1;
  localparam logic [2:0] ST_EXISTS  = 3'd2;
  localparam logic [2:0] ST_NOSPACE = 3'd3;
  localparam logic [2:0] ST_INVALID = 3'd4;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] file_id;
    logic [7:0] block_count;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] first_block;
    logic [7:0] last_block;
    logic [7:0] index_block;
    logic [8:0] free_count;
  } rsp_t;

  typedef struct packed {
    logic [7:0]    size;
    logic [BW-1:0] first;
    logic [BW-1:0] last;
    logic [BW-1:0] index;
  } entry_t;

  typedef struct packed {
    logic          start;
    logic          from_zero;
  } scan_cmd_t;

  typedef struct packed {
    logic          done;
    logic          found;
    logic [BW-1:0] blk;
  } scan_rsp_t;

endpackage

// File: rtl/liba_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// liba_scan
// Used-bit store with a one-block-per-cycle free search cursor.
// ----------------------------------------------------------------------------
module liba_scan (
  input  logic                     clk,
  input  logic                     rst,
  input  liba_pkg::scan_cmd_t      cmd,
  input  logic                     set_en,
  input  logic                     clr_en,
  input  logic [liba_pkg::BW-1:0]  wr_blk,
  output liba_pkg::scan_rsp_t      rsp
);

  logic [liba_pkg::NUM_BLOCKS-1:0] used;
  logic [liba_pkg::BW-1:0]         cursor;
  logic                            active;

  always_ff @(posedge clk) begin
    if (rst) begin
      used   <= '0;
      active <= 1'b0;
      cursor <= '0;
      rsp    <= '0;
    end else begin
      rsp.done <= 1'b0;
      if (set_en) used[wr_blk] <= 1'b1;
      if (clr_en) used[wr_blk] <= 1'b0;
      if (cmd.from_zero) begin
        cursor <= '0;
      end else if (cmd.start) begin
        active <= 1'b1;
      end else if (active) begin
        if (!used[cursor]) begin
          active    <= 1'b0;
          rsp.done  <= 1'b1;
          rsp.found <= 1'b1;
          rsp.blk   <= cursor;
        end else if (cursor == liba_pkg::BW'(liba_pkg::NUM_BLOCKS - 1)) begin
          active    <= 1'b0;
          rsp.done  <= 1'b1;
          rsp.found <= 1'b0;
        end else begin
          cursor <= cursor + 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/linked_indexed_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linked_indexed_block_allocator
// Create, resize and delete files made of linked chains of block slots.
// ----------------------------------------------------------------------------
// channel   ports                     transfer
// request   start, busy, req          start && !busy
// result    done, rsp                 done, one cycle
//
// A request passes a check state, then takes each block (and on a create the
// index block) by a scan and a wait on the free search, which steps over used
// blocks; a shrink walks the chain to its new end, and frees follow the links.
// The free search starts at block zero for each request and then resumes
// from the last block taken.
// Reset clears the used map and marks every file absent.
// The result cannot be stalled.
// ----------------------------------------------------------------------------
module linked_indexed_block_allocator (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  liba_pkg::req_t   req,
  output logic             busy,
  output logic             done,
  output liba_pkg::rsp_t   rsp
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_CHECK  = 10'b0000000010,
    S_SCAN   = 10'b0000000100,
    S_WAIT   = 10'b0000001000,
    S_WALK   = 10'b0000010000,
    S_WALKRD = 10'b0000100000,
    S_FREE   = 10'b0001000000,
    S_FREERD = 10'b0010000000,
    S_WRITE  = 10'b0100000000,
    S_REPLY  = 10'b1000000000
  } state_t;

  state_t                          state;
  liba_pkg::req_t                  cur;
  liba_pkg::entry_t                ent;
  logic [liba_pkg::NUM_FILES-1:0]  present;
  liba_pkg::entry_t                files [liba_pkg::NUM_FILES];
  logic [liba_pkg::BW-1:0]         links [liba_pkg::NUM_BLOCKS];
  logic [liba_pkg::BW-1:0]         link_rd;
  logic [liba_pkg::BW-1:0]         link_addr;
  logic                            link_we;
  logic [liba_pkg::BW-1:0]         link_wa;
  logic [liba_pkg::BW-1:0]         link_wd;
  logic [liba_pkg::CW-1:0]         free_blocks;
  logic [7:0]                      remain;
  logic [liba_pkg::BW-1:0]         blk;
  logic                            ent_present;
  logic                            need_index;
  logic                            del_index;
  logic [2:0]                      status;
  liba_pkg::scan_cmd_t             scmd;
  liba_pkg::scan_rsp_t             srsp;
  logic                            set_en;
  logic                            clr_en;
  logic [liba_pkg::BW-1:0]         wr_blk;
  logic [liba_pkg::CW-1:0]         want_c;
  logic [liba_pkg::CW-1:0]         size_c;

  liba_scan u_scan (
    .clk    (clk),
    .rst    (rst),
    .cmd    (scmd),
    .set_en (set_en),
    .clr_en (clr_en),
    .wr_blk (wr_blk),
    .rsp    (srsp)
  );

  assign busy   = (state != S_IDLE);
  assign want_c = liba_pkg::CW'(cur.block_count);
  assign size_c = liba_pkg::CW'(ent.size);

  always_ff @(posedge clk) begin
    if (link_we) links[link_wa] <= link_wd;
    link_rd <= links[link_addr];
  end

  always_ff @(posedge clk) begin
    if (state == S_WRITE) files[cur.file_id] <= ent;
  end

  always_ff @(posedge clk) begin
    if (start && !busy) ent <= files[req.file_id];
    else if (state == S_WRITE && !ent_present) ent <= '0;
    else begin
      case (state)
        S_CHECK: if (!present[cur.file_id]) ent <= '0;
        S_WAIT: if (srsp.done && !need_index) begin
          if (ent.size == 8'd0) ent.first <= srsp.blk;
          ent.last <= srsp.blk;
          ent.size <= ent.size + 8'd1;
        end else if (srsp.done) ent.index <= srsp.blk;
        S_WALK: if (remain == 8'd0) begin
          ent.last <= blk;
          ent.size <= cur.block_count;
        end
        default: ;
      endcase
      if (state == S_CHECK && cur.action == liba_pkg::ACT_RESIZE &&
          present[cur.file_id] && cur.block_count == 8'd0 && ent.size != 8'd0)
        ent.size <= cur.block_count;
    end
  end

  always_comb begin
    scmd      = '0;
    set_en    = 1'b0;
    clr_en    = 1'b0;
    wr_blk    = blk;
    link_we   = 1'b0;
    link_wa   = ent.last;
    link_wd   = '0;
    link_addr = blk;
    case (state)
      S_SCAN: begin
        scmd.start = 1'b1;
      end
      S_WAIT: if (srsp.done) begin
        set_en = 1'b1;
        wr_blk = srsp.blk;
        if (!need_index && ent.size != 8'd0) begin
          link_we = 1'b1;
          link_wa = ent.last;
          link_wd = srsp.blk;
        end
      end
      S_FREE: begin
        clr_en = 1'b1;
        wr_blk = blk;
      end
      S_FREERD: if (del_index) begin
        clr_en = 1'b1;
        wr_blk = ent.index;
      end
      default: ;
    endcase
    if (state == S_CHECK) scmd.from_zero = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      present     <= '0;
      free_blocks <= liba_pkg::CW'(liba_pkg::NUM_BLOCKS);
      done        <= 1'b0;
      status      <= liba_pkg::ST_OK;
      need_index  <= 1'b0;
      del_index   <= 1'b0;
      ent_present <= 1'b0;
      remain      <= '0;
      blk         <= '0;
      cur         <= '0;
      rsp         <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: if (start) begin
          cur   <= req;
          state <= S_CHECK;
        end
        S_CHECK: begin
          status      <= liba_pkg::ST_OK;
          ent_present <= present[cur.file_id];
          state       <= S_WRITE;
          case (cur.action)
            liba_pkg::ACT_CREATE: begin
              if (present[cur.file_id]) status <= liba_pkg::ST_EXISTS;
              else if (free_blocks < want_c + 1'b1) status <= liba_pkg::ST_NOSPACE;
              else begin
                ent_present <= 1'b1;
                present[cur.file_id] <= 1'b1;
                need_index  <= 1'b1;
                remain      <= cur.block_count;
                state       <= S_SCAN;
              end
            end
            liba_pkg::ACT_RESIZE: begin
              if (!present[cur.file_id]) status <= liba_pkg::ST_NOFILE;
              else if (cur.block_count > ent.size) begin
                if (free_blocks < want_c - size_c) status <= liba_pkg::ST_NOSPACE;
                else begin
                  need_index <= 1'b0;
                  remain     <= cur.block_count - ent.size;
                  state      <= S_SCAN;
                end
              end else if (cur.block_count < ent.size) begin
                del_index <= 1'b0;
                blk       <= ent.first;
                if (cur.block_count == 8'd0) begin
                  remain <= ent.size;
                  state  <= S_FREE;
                end else begin
                  remain <= cur.block_count - 8'd1;
                  state  <= S_WALK;
                end
              end
            end
            liba_pkg::ACT_DELETE: begin
              if (!present[cur.file_id]) status <= liba_pkg::ST_NOFILE;
              else begin
                present[cur.file_id] <= 1'b0;
                ent_present <= 1'b0;
                del_index   <= 1'b1;
                remain      <= ent.size;
                blk         <= ent.first;
                state       <= (ent.size == 8'd0) ? S_FREERD : S_FREE;
              end
            end
            default: begin
              status      <= liba_pkg::ST_INVALID;
              ent_present <= 1'b0;
            end
          endcase
        end
        S_SCAN: state <= (need_index || remain != 8'd0) ? S_WAIT : S_WRITE;
        S_WAIT: if (srsp.done) begin
          free_blocks <= free_blocks - 1'b1;
          if (need_index) need_index <= 1'b0;
          else remain <= remain - 8'd1;
          state <= S_SCAN;
          if (!need_index && remain == 8'd1) state <= S_WRITE;
          if (need_index && remain == 8'd0) state <= S_WRITE;
        end
        S_WALK: begin
          if (remain == 8'd0) begin
            remain <= ent.size - cur.block_count;
            state  <= S_FREERD;
          end else state <= S_WALKRD;
        end
        S_WALKRD: begin
          blk    <= link_rd;
          remain <= remain - 8'd1;
          state  <= S_WALK;
        end
        S_FREE: begin
          free_blocks <= free_blocks + 1'b1;
          remain      <= remain - 8'd1;
          state       <= S_FREERD;
        end
        S_FREERD: begin
          if (remain == 8'd0) begin
            if (del_index) free_blocks <= free_blocks + 1'b1;
            del_index <= 1'b0;
            state     <= S_WRITE;
          end else begin
            blk   <= link_rd;
            state <= S_FREE;
          end
        end
        S_WRITE: state <= S_REPLY;
        S_REPLY: begin
          rsp.status      <= status;
          rsp.first_block <= (ent_present && ent.size != 8'd0) ? ent.first : '0;
          rsp.last_block  <= (ent_present && ent.size != 8'd0) ? ent.last : '0;
          rsp.index_block <= ent_present ? ent.index : '0;
          rsp.free_count  <= free_blocks;
          done            <= 1'b1;
          state           <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
